/* rtl/assert_macros.svh */
// assertion macros shared by the rtl of the byte cipher
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SRBC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("srbc assertion failed");
`define SRBC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("srbc assertion failed");
`else
`define SRBC_ASSERT(lbl, clk, rst, prop)
`define SRBC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/srbc_pkg.sv */
// shared types, constants and the microcode table of the shuffle-rotate byte cipher
// no dependencies
`default_nettype none

package srbc_pkg;

   localparam int MAX_LEN_DEF = 4096;
   localparam int ROUNDS      = 3;
   localparam int ROUND_W     = 2;

   localparam logic [7:0] XOR_LO  = 8'h13;
   localparam logic [7:0] XOR_ALL = 8'hFF;
   localparam logic [7:0] OFFSET  = 8'h48;

   localparam int CSR_AW = 2;
   localparam int CSR_DW = 32;
   localparam logic [CSR_AW-1:0] REG_MODE = '0;

   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE    = 3'd0;
   localparam step_type STEP_PRIME_A = 3'd1;
   localparam step_type STEP_RUN_A   = 3'd2;
   localparam step_type STEP_PRIME_B = 3'd3;
   localparam step_type STEP_RUN_B   = 3'd4;
   localparam step_type STEP_ROUND   = 3'd5;
   localparam step_type STEP_DONE    = 3'd6;

   typedef enum logic [2:0] {
      ACT_IDLE,
      ACT_PRIME,
      ACT_RUN,
      ACT_ROUND,
      ACT_DONE
   } act_type;

   typedef enum logic [1:0] {
      OP_ENC_ASC,
      OP_ENC_DESC,
      OP_DEC_DESC,
      OP_DEC_ASC
   } pass_op_type;

   // one control word: action, which pass of the round, jump target
   typedef struct packed {
      act_type  act;
      logic     second;
      step_type jump;
   } uword_type;

   typedef struct packed {
      logic        prime;
      logic        run;
      logic        asc;
      pass_op_type op;
   } ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } seq_status_type;

   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      case (step)
         STEP_IDLE:    w = '{act: ACT_IDLE,  second: 1'b0, jump: STEP_PRIME_A};
         STEP_PRIME_A: w = '{act: ACT_PRIME, second: 1'b0, jump: STEP_RUN_A};
         STEP_RUN_A:   w = '{act: ACT_RUN,   second: 1'b0, jump: STEP_PRIME_B};
         STEP_PRIME_B: w = '{act: ACT_PRIME, second: 1'b1, jump: STEP_RUN_B};
         STEP_RUN_B:   w = '{act: ACT_RUN,   second: 1'b1, jump: STEP_ROUND};
         STEP_ROUND:   w = '{act: ACT_ROUND, second: 1'b0, jump: STEP_PRIME_A};
         STEP_DONE:    w = '{act: ACT_DONE,  second: 1'b0, jump: STEP_IDLE};
         default:      w = '{act: ACT_DONE,  second: 1'b0, jump: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* rtl/srbc_ram.sv */
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module srbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/srbc_seq.sv */
// microcoded sequencer: step counter, round counter and control word decode
// depends on srbc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module srbc_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic                    dec,
   input  wire logic                    last,
   output srbc_pkg::ctrl_type           ctrl,
   output srbc_pkg::seq_status_type     status
);

   srbc_pkg::step_type             step_ff, step_in;
   logic [srbc_pkg::ROUND_W-1:0]   round_ff, round_in;
   srbc_pkg::uword_type            uw;

   assign uw = srbc_pkg::ucode_rom(step_ff);

   // next step
   always_comb begin
      step_in  = step_ff;
      round_in = round_ff;
      unique case (uw.act)
         srbc_pkg::ACT_IDLE: begin
            if (start) step_in = uw.jump;
         end
         srbc_pkg::ACT_PRIME: begin
            step_in = uw.jump;
         end
         srbc_pkg::ACT_RUN: begin
            if (last) step_in = uw.jump;
         end
         srbc_pkg::ACT_ROUND: begin
            if (round_ff == srbc_pkg::ROUND_W'(srbc_pkg::ROUNDS - 1)) begin
               round_in = '0;
               step_in  = srbc_pkg::STEP_W'(step_ff + 1'b1);
            end else begin
               round_in = srbc_pkg::ROUND_W'(round_ff + 1'b1);
               step_in  = uw.jump;
            end
         end
         srbc_pkg::ACT_DONE: begin
            step_in = uw.jump;
         end
         default: begin
            step_in = srbc_pkg::STEP_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      ctrl.prime = (uw.act == srbc_pkg::ACT_PRIME);
      ctrl.run   = (uw.act == srbc_pkg::ACT_RUN);
      // encrypt runs ascending first, decrypt descending first
      ctrl.asc   = (uw.second == dec);
      unique case ({dec, uw.second})
         2'b00:   ctrl.op = srbc_pkg::OP_ENC_ASC;
         2'b01:   ctrl.op = srbc_pkg::OP_ENC_DESC;
         2'b10:   ctrl.op = srbc_pkg::OP_DEC_DESC;
         default: ctrl.op = srbc_pkg::OP_DEC_ASC;
      endcase
      status.busy = (step_ff != srbc_pkg::STEP_IDLE);
      status.done = (uw.act == srbc_pkg::ACT_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= srbc_pkg::STEP_IDLE;
         round_ff <= '0;
      end else begin
         step_ff  <= step_in;
         round_ff <= round_in;
      end
   end

   `SRBC_ASSERT(a_round_range, clock, reset, round_ff <= srbc_pkg::ROUND_W'(srbc_pkg::ROUNDS - 1))
   `SRBC_ASSERT(a_done_to_idle, clock, reset, status.done |=> step_ff == srbc_pkg::STEP_IDLE)

endmodule

`default_nettype wire

/* rtl/srbc_dp.sv */
// pass datapath: position count, buffer index, chain byte and the byte transform
// depends on srbc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module srbc_dp #(
   parameter int MAX_LEN = srbc_pkg::MAX_LEN_DEF,
   parameter int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
   parameter int LW      = $clog2(MAX_LEN + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire srbc_pkg::ctrl_type ctrl,
   input  wire logic [LW-1:0]      n,
   input  wire logic [7:0]         rd_data,
   output logic                    rd_en,
   output logic      [AW-1:0]      rd_addr,
   output logic                    wr_en,
   output logic      [AW-1:0]      wr_addr,
   output logic      [7:0]         wr_data,
   output logic                    last
);

   logic [LW-1:0] t_ff, t_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [7:0]    chain_ff, chain_in;
   logic [AW-1:0] first_idx, next_idx;
   logic [7:0]    t8;
   logic [2:0]    t3;
   logic [7:0]    link, res;

   function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] k);
      logic [15:0] w;
      w = {v, v} << k;
      return w[15:8];
   endfunction

   function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] k);
      logic [15:0] w;
      w = {v, v} >> k;
      return w[7:0];
   endfunction

   assign t8        = 8'(t_ff);
   assign t3        = t8[2:0];
   assign first_idx = ctrl.asc ? '0 : AW'(n - 1'b1);
   assign next_idx  = ctrl.asc ? AW'(idx_ff + 1'b1) : AW'(idx_ff - 1'b1);
   assign last      = (t_ff == LW'(1));

   // link is the new chain value, res the byte written back
   always_comb begin
      unique case (ctrl.op)
         srbc_pkg::OP_ENC_ASC: begin
            link = 8'(rotl8(rd_data, 3'd3) + t8) ^ chain_ff;
            res  = 8'((rotr8(link, t3) ^ srbc_pkg::XOR_ALL) + srbc_pkg::OFFSET);
         end
         srbc_pkg::OP_ENC_DESC: begin
            link = 8'(rotl8(rd_data, 3'd4) + t8) ^ chain_ff;
            res  = rotr8(link ^ srbc_pkg::XOR_LO, 3'd3);
         end
         srbc_pkg::OP_DEC_DESC: begin
            link = rotl8(rd_data, 3'd3) ^ srbc_pkg::XOR_LO;
            res  = rotr8(8'((link ^ chain_ff) - t8), 3'd4);
         end
         default: begin
            link = rotl8(8'(rd_data - srbc_pkg::OFFSET) ^ srbc_pkg::XOR_ALL, t3);
            res  = rotr8(8'((link ^ chain_ff) - t8), 3'd3);
         end
      endcase
   end

   always_comb begin
      t_in     = t_ff;
      idx_in   = idx_ff;
      chain_in = chain_ff;
      rd_en    = 1'b0;
      rd_addr  = first_idx;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = res;
      if (ctrl.prime) begin
         t_in     = n;
         idx_in   = first_idx;
         chain_in = '0;
         rd_en    = 1'b1;
      end else if (ctrl.run) begin
         // write this byte back while the next one is read
         wr_en    = 1'b1;
         rd_en    = 1'b1;
         rd_addr  = next_idx;
         t_in     = LW'(t_ff - 1'b1);
         idx_in   = next_idx;
         chain_in = link;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else begin
         chain_ff <= chain_in;
      end
      t_ff   <= t_in;
      idx_ff <= idx_in;
   end

   `SRBC_ASSERT(a_run_count_live, clock, reset, ctrl.run |-> t_ff != '0)

endmodule

`default_nettype wire

/* rtl/shuffle_rotate_byte_cipher_top.sv */
// top level of the shuffle-rotate byte cipher: handshakes, csr, packet buffer
// depends on srbc_pkg, srbc_ram, srbc_seq, srbc_dp and assert_macros.svh
//
//   channel   direction  ports                                  flow control
//   req       in         req_command, req_data_in, req_final_in  req_valid / req_stall
//   rsp       out        rsp_data_out, rsp_final_out             rsp_valid / rsp_stall
//   csr       in/out     csr_paddr, csr_pwdata, csr_prdata       psel / penable / pready
//
// a read word's byte appears on rsp in the cycle after the word is accepted
// a final load runs 3 rounds of two passes over the n stored bytes, the buffer ram doing
// one read and one write-back per cycle of a pass; req_stall is high meanwhile
// reset is synchronous, clears control state; buffer contents are undefined until loaded
// req_stall also rises while a result is held by rsp_stall
`default_nettype none
`include "assert_macros.svh"

module shuffle_rotate_byte_cipher_top #(
   parameter int MAX_LEN = srbc_pkg::MAX_LEN_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_command,
   input  wire logic [7:0]                  req_data_in,
   input  wire logic                        req_final_in,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [7:0]                  rsp_data_out,
   output logic                             rsp_final_out,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [srbc_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [srbc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [srbc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                             csr_pready
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LW = $clog2(MAX_LEN + 1);

   logic          mode_ff, mode_in;
   logic          dec_ff, dec_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] ptr_ff, ptr_in;
   logic          ready_ff, ready_in;
   logic          loading_ff, loading_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_final_ff, rsp_final_in;

   logic          in_acc, load_acc, read_acc, rd_fire, start, room;
   logic [LW-1:0] eff_len, ptr_next;
   logic          csr_wr;

   srbc_pkg::ctrl_type       ctrl;
   srbc_pkg::seq_status_type status;
   logic                     dp_last;
   logic                     dp_rd_en, dp_wr_en;
   logic [AW-1:0]            dp_rd_addr, dp_wr_addr;
   logic [7:0]               dp_wr_data;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   // handshakes
   assign req_stall = status.busy || (rsp_valid_ff && rsp_stall);
   assign in_acc    = req_valid && !req_stall;
   assign load_acc  = in_acc && !req_command;
   assign read_acc  = in_acc && req_command;
   assign rd_fire   = read_acc && ready_ff;
   assign start     = load_acc && req_final_in;

   assign eff_len  = loading_ff ? len_ff : '0;
   assign room     = (eff_len < LW'(MAX_LEN));
   assign ptr_next = LW'(ptr_ff + 1'b1);

   // csr
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == srbc_pkg::REG_MODE) ?
                       srbc_pkg::CSR_DW'(mode_ff) : '0;

   always_comb begin
      mode_in      = mode_ff;
      dec_in       = dec_ff;
      len_in       = len_ff;
      ptr_in       = ptr_ff;
      ready_in     = ready_ff;
      loading_in   = loading_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_final_in = rsp_final_ff;
      if (csr_wr && (csr_paddr == srbc_pkg::REG_MODE)) begin
         mode_in = csr_pwdata[0];
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_acc) begin
         // bytes beyond the buffer are dropped
         len_in     = room ? LW'(eff_len + 1'b1) : eff_len;
         ptr_in     = '0;
         ready_in   = 1'b0;
         loading_in = !req_final_in;
         if (req_final_in) begin
            dec_in = mode_ff;
         end
      end else if (read_acc) begin
         if (ready_ff) begin
            ptr_in       = ptr_next;
            rsp_valid_in = 1'b1;
            rsp_final_in = (ptr_next == len_ff);
            if (ptr_next == len_ff) begin
               ready_in = 1'b0;
            end
         end else begin
            ready_in = 1'b0;
         end
      end
      if (status.done) begin
         ready_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         dec_ff       <= 1'b0;
         len_ff       <= '0;
         ptr_ff       <= '0;
         ready_ff     <= 1'b0;
         loading_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         dec_ff       <= dec_in;
         len_ff       <= len_in;
         ptr_ff       <= ptr_in;
         ready_ff     <= ready_in;
         loading_ff   <= loading_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_final_ff <= rsp_final_in;
   end

   // buffer ports go to the datapath while a transform runs
   always_comb begin
      if (status.busy) begin
         ram_we    = dp_wr_en;
         ram_waddr = dp_wr_addr;
         ram_wdata = dp_wr_data;
         ram_re    = dp_rd_en;
         ram_raddr = dp_rd_addr;
      end else begin
         ram_we    = load_acc && room;
         ram_waddr = AW'(eff_len);
         ram_wdata = req_data_in;
         ram_re    = rd_fire;
         ram_raddr = AW'(ptr_ff);
      end
   end

   srbc_ram #(
      .WIDTH (8),
      .DEPTH (MAX_LEN),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   srbc_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .dec    (dec_ff),
      .last   (dp_last),
      .ctrl   (ctrl),
      .status (status)
   );

   srbc_dp #(
      .MAX_LEN (MAX_LEN),
      .AW      (AW),
      .LW      (LW)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .n       (len_ff),
      .rd_data (ram_rdata),
      .rd_en   (dp_rd_en),
      .rd_addr (dp_rd_addr),
      .wr_en   (dp_wr_en),
      .wr_addr (dp_wr_addr),
      .wr_data (dp_wr_data),
      .last    (dp_last)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_out  = ram_rdata;
   assign rsp_final_out = rsp_final_ff;

   `SRBC_ASSERT(a_no_result_while_busy, clock, reset, status.busy |-> !rsp_valid_ff)
   `SRBC_ASSERT(a_ready_in_range, clock, reset, ready_ff |-> ptr_ff < len_ff)
   `SRBC_ASSERT_ALWAYS(a_len_bound, clock, reset || len_ff <= LW'(MAX_LEN))

endmodule

`default_nettype wire
